// ===== hdl/size_class_bucket_allocator_macros.svh =====
// Assertion macros shared by the size class bucket allocator.
// No dependencies; included by the top level only.
`ifndef SIZE_CLASS_BUCKET_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BUCKET_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ===== hdl/scba_pkg.sv =====
// Package of the size class bucket allocator: field widths, status codes,
// controller states, command and status structs, class size function.
// No dependencies.
package scba_pkg;

  localparam int HANDLE_W     = 10;
  localparam int LEN_W        = 16;
  localparam int STATUS_W     = 2;
  localparam int CLASS_SIZE_W = 20;
  localparam int MIN_CLASS_SIZE = 16;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_TOO_LARGE  = 2'd1,
    ST_NO_SLOTS   = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic commit;
    logic clear_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

  function automatic logic [CLASS_SIZE_W-1:0] class_size(input logic [3:0] cls);
    return CLASS_SIZE_W'(MIN_CLASS_SIZE) << cls;
  endfunction

endpackage

// ===== hdl/scba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module scba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/scba_ctrl.sv =====
// Controller of the size class bucket allocator: clearing pass, accept and
// commit sequencing, output valid. Depends on scba_pkg.
module scba_ctrl import scba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/scba_dp.sv =====
// Datapath of the size class bucket allocator: request decode, per-class
// counters, free stack and usage map memories, result register.
// Depends on scba_pkg and scba_ram.
module scba_dp import scba_pkg::*; #(
  parameter int SLOTS   = 64,
  parameter int CLASSES = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          sts,
  input  logic                in_mode,
  input  logic [LEN_W-1:0]    in_request_length,
  input  logic [HANDLE_W-1:0] in_handle_in,
  input  logic [LEN_W-1:0]    in_size_hint,
  output logic [HANDLE_W-1:0] out_handle_out,
  output logic [STATUS_W-1:0] out_status
);

  localparam int TOTAL  = SLOTS * CLASSES;
  localparam int IDX_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CLS_W  = (CLASSES > 1) ? $clog2(CLASSES) : 1;

  logic [CNT_W-1:0] free_top_r [CLASSES];
  logic [CNT_W-1:0] created_r  [CLASSES];
  logic [IDX_W-1:0] clr_r;

  logic               mode_r;
  logic [CLS_W-1:0]   cls_r;
  logic [IDX_W-1:0]   base_r;
  logic [IDX_W-1:0]   hidx_r;
  logic [SLOT_W-1:0]  slot_r;
  logic               pop_r;
  status_t            pre_st_r;
  logic [HANDLE_W-1:0] out_handle_r;
  status_t            out_status_r;

  logic               fit_a, class_ok, hint_ok, pop_d;
  logic [CLS_W-1:0]   cls_a, cls_f, cls_d;
  logic [IDX_W-1:0]   base_a, base_f, base_d;
  logic [SLOT_W-1:0]  slot_f, slot_d;
  logic [CNT_W-1:0]   top_d, cnt_d, top_e;
  status_t            pre_st_d;
  logic [31:0]        slot_diff;

  logic               stk_re, stk_we, use_re, use_we;
  logic [IDX_W-1:0]   stk_raddr, stk_waddr, use_raddr, use_waddr;
  logic [SLOT_W-1:0]  stk_rdata;
  logic [0:0]         use_wdata, use_rdata;

  logic [SLOT_W-1:0]  slot_e;
  logic [IDX_W-1:0]   idx_e;
  logic               ok_e;
  status_t            st_e;
  logic [HANDLE_W-1:0] handle_e;

  always_comb begin
    fit_a  = 1'b0;
    cls_a  = '0;
    base_a = '0;
    for (int k = CLASSES - 1; k >= 0; k--) begin
      if ({4'b0, in_request_length} <= class_size(4'(k))) begin
        fit_a  = 1'b1;
        cls_a  = CLS_W'(k);
        base_a = IDX_W'(k * SLOTS);
      end
    end

    cls_f  = '0;
    base_f = '0;
    for (int k = 1; k < CLASSES; k++) begin
      if (32'(in_handle_in) >= 32'(k * SLOTS)) begin
        cls_f  = CLS_W'(k);
        base_f = IDX_W'(k * SLOTS);
      end
    end
    class_ok  = 32'(in_handle_in) < 32'(TOTAL);
    slot_diff = 32'(in_handle_in) - 32'(base_f);
    slot_f    = SLOT_W'(slot_diff);
    hint_ok   = (in_size_hint == '0) ||
                ({4'b0, in_size_hint} <= class_size(4'(cls_f)));

    cls_d  = (in_mode == MODE_FREE) ? cls_f : cls_a;
    base_d = (in_mode == MODE_FREE) ? base_f : base_a;
    top_d  = free_top_r[cls_d];
    cnt_d  = created_r[cls_d];

    pop_d    = 1'b0;
    slot_d   = slot_f;
    pre_st_d = ST_OK;
    if (in_mode == MODE_ALLOC) begin
      slot_d = SLOT_W'(cnt_d);
      if (!fit_a) begin
        pre_st_d = ST_TOO_LARGE;
      end else if (top_d != '0) begin
        pop_d = 1'b1;
      end else if (cnt_d >= CNT_W'(SLOTS)) begin
        pre_st_d = ST_NO_SLOTS;
      end
    end else if (!class_ok || !hint_ok || top_d >= CNT_W'(SLOTS)) begin
      pre_st_d = ST_BAD_HANDLE;
    end

    stk_re    = cmd.accept && (in_mode == MODE_ALLOC) && pop_d;
    stk_raddr = base_d + IDX_W'(top_d - CNT_W'(1));
    use_re    = cmd.accept && (in_mode == MODE_FREE);
    use_raddr = IDX_W'(in_handle_in);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r   <= in_mode;
      cls_r    <= cls_d;
      base_r   <= base_d;
      hidx_r   <= IDX_W'(in_handle_in);
      slot_r   <= slot_d;
      pop_r    <= pop_d;
      pre_st_r <= pre_st_d;
    end
    if (cmd.commit) begin
      out_handle_r <= handle_e;
      out_status_r <= st_e;
    end
  end

  always_comb begin
    slot_e = pop_r ? stk_rdata : slot_r;
    idx_e  = base_r + IDX_W'(slot_e);
    top_e  = free_top_r[cls_r];
    if (mode_r == MODE_ALLOC) begin
      ok_e     = (pre_st_r == ST_OK);
      st_e     = pre_st_r;
      handle_e = ok_e ? HANDLE_W'(idx_e) : '0;
    end else begin
      ok_e     = (pre_st_r == ST_OK) && use_rdata[0];
      st_e     = ok_e ? ST_OK : ST_BAD_HANDLE;
      handle_e = '0;
    end

    stk_we    = cmd.commit && ok_e && (mode_r == MODE_FREE);
    stk_waddr = base_r + IDX_W'(top_e);

    use_we    = 1'b0;
    use_waddr = idx_e;
    use_wdata = 1'b1;
    if (cmd.clear_step) begin
      use_we    = 1'b1;
      use_waddr = clr_r;
      use_wdata = 1'b0;
    end else if (cmd.commit && ok_e) begin
      use_we = 1'b1;
      if (mode_r == MODE_FREE) begin
        use_waddr = hidx_r;
        use_wdata = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      for (int k = 0; k < CLASSES; k++) begin
        free_top_r[k] <= '0;
        created_r[k]  <= '0;
      end
    end else begin
      if (cmd.clear_step) begin
        clr_r <= clr_r + IDX_W'(1);
      end
      if (cmd.commit && ok_e) begin
        if (mode_r == MODE_FREE) begin
          free_top_r[cls_r] <= top_e + CNT_W'(1);
        end else if (pop_r) begin
          free_top_r[cls_r] <= top_e - CNT_W'(1);
        end else begin
          created_r[cls_r] <= created_r[cls_r] + CNT_W'(1);
        end
      end
    end
  end

  assign sts.clear_last = (clr_r == IDX_W'(TOTAL - 1));

  scba_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TOTAL)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(slot_r),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  scba_ram #(
    .WIDTH(1),
    .DEPTH(TOTAL)
  ) u_use_ram (
    .clk  (clk),
    .we   (use_we),
    .waddr(use_waddr),
    .wdata(use_wdata),
    .re   (use_re),
    .raddr(use_raddr),
    .rdata(use_rdata)
  );

  assign out_handle_out = out_handle_r;
  assign out_status     = out_status_r;

endmodule

// ===== hdl/size_class_bucket_allocator.sv =====
// Top level of the size class bucket allocator: controller and datapath.
// Depends on scba_pkg, scba_ctrl, scba_dp and the assertion macro header.
//
// Each word on the input side is one allocate or free request and yields one
// result word. The accept step of a request decodes it and issues the
// registered reads of the free stack and usage map memories, and the commit
// step then commits the memory writes and loads the result register.
// A new request is taken in the cycle after a commit, also while the previous
// result is still stalled at the output; a commit waits while that result is
// held. After reset the usage map is cleared one entry a cycle, so in_stall
// stays high until the whole usage map is cleared.
`include "size_class_bucket_allocator_macros.svh"

module size_class_bucket_allocator import scba_pkg::*; #(
  parameter int SLOTS   = 64,
  parameter int CLASSES = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [LEN_W-1:0]    in_request_length,
  input  logic [HANDLE_W-1:0] in_handle_in,
  input  logic [LEN_W-1:0]    in_size_hint,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HANDLE_W-1:0] out_handle_out,
  output logic [STATUS_W-1:0] out_status
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  scba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  scba_dp #(
    .SLOTS  (SLOTS),
    .CLASSES(CLASSES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_request_length(in_request_length),
    .in_handle_in     (in_handle_in),
    .in_size_hint     (in_size_hint),
    .out_handle_out   (out_handle_out),
    .out_status       (out_status)
  );

  `SCBA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)
  `SCBA_ASSERT_IMPL(a_err_handle_zero, clk, rst_n, out_valid && (out_status != ST_OK), out_handle_out == '0)
  `SCBA_ASSERT_IMPL(a_handle_range, clk, rst_n, out_valid, 32'(out_handle_out) < 32'(SLOTS * CLASSES))

endmodule
